FILE: rtl/integer_to_ascii_radix_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII radix converter
// Implication and never-true checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

`ifndef SYNTHESIS
`define ITAR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ITAR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define ITAR_ASSERT_IMPL(label, ante, cons, msg)
`define ITAR_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: rtl/itar_pkg.sv
// ----------------------------------------------------------------------------
// itar_pkg
// Types, constants and helper functions shared by the radix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itar_pkg;

  localparam int VALUE_W   = 64;
  localparam int RADIX_W   = 6;
  localparam int DIGIT_W   = 6;
  localparam int CHAR_W    = 8;
  // Dividend bits retired by the divider in one cycle.
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = VALUE_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               kind;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_LOAD
  } state_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d >= 6'd10) begin
      res = CHAR_LOWER_A + {2'b00, d} - 8'd10;
    end else begin
      res = CHAR_ZERO + {2'b00, d};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/itar_divider.sv
// ----------------------------------------------------------------------------
// itar_divider
// Iterative 64-bit by 6-bit restoring divider, several quotient bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itar_divider
  import itar_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [VALUE_W-1:0] quo_r, quo_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [RADIX_W-1:0] dvs_r;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  // One step: shift the top dividend bits into the partial remainder,
  // subtracting the divisor whenever it fits.
  always_comb begin
    logic [DIGIT_W:0]    part;
    logic [DIGIT_W-1:0]  rem_v;
    logic [DIV_BITS-1:0] qbits;
    rem_v = rem_r;
    qbits = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      part = {rem_v, quo_r[VALUE_W-1-i]};
      if (part >= {1'b0, dvs_r}) begin
        part = part - {1'b0, dvs_r};
        qbits[DIV_BITS-1-i] = 1'b1;
      end
      rem_v = part[DIGIT_W-1:0];
    end

    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = STEP_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[VALUE_W-DIV_BITS-1:0], qbits};
      rem_nxt = rem_v;
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

FILE: rtl/itar_digit_ram.sv
// ----------------------------------------------------------------------------
// itar_digit_ram
// Digit buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module itar_digit_ram
  import itar_pkg::*;
#(
  parameter int DEPTH  = 22,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire logic [DIGIT_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output      logic [DIGIT_W-1:0] rd_data
);

  logic [DIGIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts one 64-bit integer, unsigned or signed, into ASCII text in the
// radix held in the configuration register (values below 8 act as 8, above
// 36 as 36). Characters leave most significant first, a '-' leads negative
// signed values, zero gives "0", and last marks the final character. One
// transaction is handled at a time and in_stall stays high until its text is
// generated. Each digit is computed by the shared divider, which retires
// eight dividend bits per cycle, and each character is then read through
// the digit buffer read port in ST_READ and loaded into the output
// register in ST_LOAD, which waits while the output side stalls.
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_to_ascii_radix_macros.svh"

module integer_to_ascii_radix
  import itar_pkg::*;
#(
  parameter int MAX_DIGITS = 22
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire in_t                in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      out_t               out_data,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [RADIX_W-1:0] cfg_data
);

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W = $clog2(MAX_DIGITS);

  state_t             state_r, state_nxt;
  logic [RADIX_W-1:0] radix_r;
  logic [VALUE_W-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               neg_r, neg_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [DIGIT_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [DIGIT_W-1:0] mem_rdata;

  logic               in_accept;
  logic               out_free;
  logic               out_load;
  logic               more_digits;
  logic [CNT_W-1:0]   count_m1;
  logic [VALUE_W-1:0] magnitude;
  logic               in_neg;

  assign in_accept   = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign more_digits = (quot_r != '0) && (count_r < CNT_W'(MAX_DIGITS));
  assign count_m1    = count_r - CNT_W'(1);
  assign in_neg      = in_data.kind && in_data.value[VALUE_W-1];
  assign magnitude   = in_neg ? (~in_data.value + VALUE_W'(1)) : in_data.value;

  itar_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  itar_digit_ram #(
    .DEPTH  (MAX_DIGITS),
    .ADDR_W (ADDR_W)
  ) u_digit_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (more_digits) begin
          state_nxt = ST_DIV;
        end else if (neg_r) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          state_nxt = (count_r == CNT_W'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall         = 1'b1;
    div_req.start    = 1'b0;
    div_req.dividend = quot_r;
    div_req.divisor  = clamp_radix(radix_r);
    mem_we           = 1'b0;
    mem_waddr        = count_r[ADDR_W-1:0];
    mem_wdata        = div_rsp.remainder;
    mem_re           = 1'b0;
    mem_raddr        = count_m1[ADDR_W-1:0];
    out_load         = 1'b0;
    out_data_nxt     = out_data_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_CHECK: begin
        if (more_digits) begin
          div_req.start = 1'b1;
        end else if (count_r == '0) begin
          // A zero value still spells one digit.
          mem_we    = 1'b1;
          mem_wdata = '0;
        end
      end
      ST_DIV: begin
        mem_we = div_rsp.done;
      end
      ST_SIGN: begin
        out_load               = out_free;
        out_data_nxt.character = CHAR_MINUS;
        out_data_nxt.last      = 1'b0;
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_LOAD: begin
        out_load               = out_free;
        out_data_nxt.character = digit_char(mem_rdata);
        out_data_nxt.last      = (count_r == CNT_W'(1));
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Datapath registers of the sequencer.
  always_comb begin
    quot_nxt  = quot_r;
    count_nxt = count_r;
    neg_nxt   = neg_r;
    if (in_accept) begin
      quot_nxt  = magnitude;
      count_nxt = '0;
      neg_nxt   = in_neg;
    end else if (state_r == ST_CHECK && !more_digits && count_r == '0) begin
      count_nxt = CNT_W'(1);
    end else if (state_r == ST_DIV && div_rsp.done) begin
      quot_nxt  = div_rsp.quotient;
      count_nxt = count_r + CNT_W'(1);
    end else if (state_r == ST_LOAD && out_free) begin
      count_nxt = count_m1;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= RADIX_RESET;
      quot_r      <= '0;
      count_r     <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      quot_r      <= quot_nxt;
      count_r     <= count_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        radix_r <= cfg_data;
      end
    end
  end

  // A character waiting under out_stall holds until it is taken.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ITAR_ASSERT_IMPL(a_div_done_in_div, div_rsp.done, state_r == ST_DIV, "stray done")
  `ITAR_ASSERT_NEVER(a_count_bound, count_r > CNT_W'(MAX_DIGITS), "digit count too high")
  `ITAR_ASSERT_NEVER(a_emit_has_digit, mem_re && count_r == '0, "read with no digit left")
  `ITAR_ASSERT_NEVER(a_write_in_range, mem_we && count_r >= CNT_W'(MAX_DIGITS), "write overflow")

endmodule

`default_nettype wire

FILE: tb/integer_to_ascii_radix_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_test
// Self-checking bench for the radix converter. A short table of numbers covers
// zero, the signed and unsigned extremes and saturating radix values on both
// sides of the range. A random run then converts several hundred numbers under
// a series of radix settings. Each character is compared with a predictor of
// the conversion while both handshakes stall in random bursts, but for the final phase.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_test;
  import itar_pkg::*;

  localparam int DIGIT_LIMIT = 22;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 300;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 51;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               kind;
    logic [RADIX_W-1:0] radix;
    string              text;
  } number_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_t                in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [RADIX_W-1:0] cfg_data  = '0;

  logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
  out_t               expected_chars[$];
  number_row_t        number_table[$];
  out_t               oldest;
  bit                 sender_up      = 1'b0;
  bit                 calm           = 1'b0;
  int                 stall_left     = 0;
  int                 idle_cycles    = 0;
  int                 error_count    = 0;
  int                 numbers_sent   = 0;
  int                 negatives_sent = 0;
  int                 chars_checked  = 0;
  int                 radix_writes   = 0;

  integer_to_ascii_radix #(
    .MAX_DIGITS(DIGIT_LIMIT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [VALUE_W-1:0] effective_radix();
    logic [VALUE_W-1:0] base;
    base = VALUE_W'(radix_reg);
    if (radix_reg < RADIX_MIN) begin
      base = VALUE_W'(RADIX_MIN);
    end else if (radix_reg > RADIX_MAX) begin
      base = VALUE_W'(RADIX_MAX);
    end
    return base;
  endfunction

  // Expected text of one number under the current radix, one entry per character.
  function automatic void spell_number(input in_t item);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] base;
    logic [DIGIT_W-1:0] digits[DIGIT_LIMIT];
    logic               neg;
    out_t               c;
    int                 n;
    base = effective_radix();
    neg  = item.kind & item.value[VALUE_W-1];
    mag  = neg ? -item.value : item.value;
    n    = 0;
    // Zero still produces one digit, so the division runs at least once.
    do begin
      digits[n] = DIGIT_W'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0 && n < DIGIT_LIMIT);
    if (neg) begin
      c.character = CHAR_MINUS;
      c.last      = 1'b0;
      expected_chars.push_back(c);
    end
    for (int k = n - 1; k >= 0; k--) begin
      if (digits[k] >= 10) begin
        c.character = CHAR_LOWER_A + CHAR_W'(digits[k]) - 8'd10;
      end else begin
        c.character = CHAR_ZERO + CHAR_W'(digits[k]);
      end
      c.last = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic void queue_text(input string text);
    out_t c;
    for (int i = 0; i < text.len(); i++) begin
      c.character = text[i];
      c.last      = (i == text.len() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic void add_row(input logic [VALUE_W-1:0] value, input logic kind,
                                  input logic [RADIX_W-1:0] radix, input string text);
    number_row_t row;
    row.value = value;
    row.kind  = kind;
    row.radix = radix;
    row.text  = text;
    number_table.push_back(row);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 6))
      0: v = {$urandom, $urandom};
      1: v = VALUE_W'($urandom_range(0, 2000));
      2: v = -VALUE_W'($urandom_range(1, 2000));
      3: v = VALUE_W'(1) << $urandom_range(0, 63);
      4: v = {VALUE_W{1'b1}} >> $urandom_range(0, 63);
      5: begin
        // Powers of the radix and their neighbors move the digit count by one.
        v = VALUE_W'(1);
        repeat ($urandom_range(1, 21)) v = v * effective_radix();
        v = v + VALUE_W'($urandom_range(0, 2)) - 1;
      end
      default: v = {1'b1, 31'($urandom), 32'($urandom)};
    endcase
    return v;
  endfunction

  task automatic hold_until_drained();
    if (sender_up) begin
      in_valid  <= 1'b0;
      sender_up  = 1'b0;
    end
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    hold_until_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radix_reg  = r;
    radix_writes++;
  endtask

  // An empty text means the predictor supplies the expected characters.
  task automatic send_number(input logic [VALUE_W-1:0] value, input logic kind,
                             input string text);
    in_t item;
    item.value = value;
    item.kind  = kind;
    if (!calm && $urandom_range(0, 4) == 0) begin
      if (sender_up) begin
        in_valid  <= 1'b0;
        sender_up  = 1'b0;
      end
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= item;
    sender_up  = 1'b1;
    do @(posedge clk); while (in_stall);
    if (text.len() != 0) begin
      queue_text(text);
    end else begin
      spell_number(item);
    end
    numbers_sent++;
    if (kind && value[VALUE_W-1]) begin
      negatives_sent++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 11) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h", out_data.character));
      end else begin
        oldest = expected_chars.pop_front();
        if (out_data.character !== oldest.character) begin
          report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                    out_data.character, oldest.character));
        end
        if (out_data.last !== oldest.last) begin
          report_mismatch($sformatf("last %b, expected %b", out_data.last, oldest.last));
        end
        chars_checked++;
      end
    end
  end

  // Ends the run when no channel completes a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("[integer_to_ascii_radix] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [RADIX_W-1:0] phase_radix;
    add_row(64'd0, 1'b0, 6'd10, "0");
    add_row(64'd0, 1'b1, 6'd10, "0");
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd10, "18446744073709551615");
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd10, "-1");
    add_row(64'h8000_0000_0000_0000, 1'b1, 6'd10, "-9223372036854775808");
    add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 6'd10, "9223372036854775807");
    add_row(64'd9, 1'b0, 6'd10, "9");
    add_row(64'd10, 1'b1, 6'd10, "10");
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd8, "1777777777777777777777");
    add_row(64'h8000_0000_0000_0000, 1'b1, 6'd8, "-1000000000000000000000");
    add_row(64'd7, 1'b0, 6'd8, "7");
    add_row(64'd35, 1'b0, 6'd36, "z");
    add_row(64'd36, 1'b0, 6'd36, "10");
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd36, "3w5e11264sgsf");
    add_row(64'hFFFF_FFFF_FFFF_FFDD, 1'b1, 6'd36, "-z");
    add_row(64'hDEAD_BEEF_0123_4567, 1'b0, 6'd16, "deadbeef01234567");
    add_row(64'hFFFF_FFFF_FFFF_FFF6, 1'b1, 6'd16, "-a");
    // Radix values outside 8..36 saturate to the nearest bound.
    add_row(64'd64, 1'b0, 6'd0, "100");
    add_row(64'd8, 1'b1, 6'd7, "10");
    add_row(64'd36, 1'b0, 6'd37, "10");
    add_row(64'd71, 1'b1, 6'd63, "1z");
    add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 6'd63, "");
    add_row(64'hFEDC_BA98_7654_3210, 1'b1, 6'd12, "");
    add_row(64'h0123_4567_89AB_CDEF, 1'b1, 6'd31, "");

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (number_table[i]) begin
      if (number_table[i].radix != radix_reg) begin
        write_radix(number_table[i].radix);
      end
      send_number(number_table[i].value, number_table[i].kind, number_table[i].text);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_radix = RADIX_MIN;
        1: phase_radix = RADIX_MAX;
        2, 3: phase_radix = RADIX_W'($urandom_range(0, 63));
        4: phase_radix = RADIX_W'($urandom_range(9, 35));
        5: phase_radix = RADIX_RESET;
        default: phase_radix = RADIX_W'($urandom_range(8, 36));
      endcase
      write_radix(phase_radix);
      if (p == PHASES - 1) begin
        calm = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Let the converter run completely dry once in the middle of a phase.
        if (p == 1 && i == PHASE_ITEMS / 2) begin
          hold_until_drained();
        end
        send_number(random_value(), 1'($urandom_range(0, 1)), "");
      end
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d numbers, %0d of them negative signed, into %0d characters.",
             numbers_sent, negatives_sent, chars_checked);
    $display("Radix register written %0d times, saturating settings included.",
             radix_writes);
    if (error_count == 0) begin
      $display("[integer_to_ascii_radix] OK");
    end else begin
      $display("[integer_to_ascii_radix] ERROR");
    end
    $finish;
  end

endmodule
